>>> src/bot_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bot_pkg: shared types for the bounding box overlap tracker
// Beat types, result codes, register indexes and the box overlap test.
// ----------------------------------------------------------------------------
package bot_pkg;

   localparam int COORD_W = 12;
   localparam int SIZE_W  = 13;
   localparam int OFFS_W  = 10;
   localparam int OID_W   = 6;
   localparam int ID_W    = 8;
   localparam int CNT_W   = 9;

   typedef enum logic [1:0] {
      CODE_NONE  = 2'd0,
      CODE_MATCH = 2'd1,
      CODE_NEW   = 2'd2,
      CODE_FULL  = 2'd3
   } code_type;

   localparam logic [1:0] CSR_Y_START     = 2'd0;
   localparam logic [1:0] CSR_Y_END       = 2'd1;
   localparam logic [1:0] CSR_EDGE_OFFSET = 2'd2;

   typedef struct packed {
      logic [COORD_W-1:0] point_x;
      logic [COORD_W-1:0] point_y;
      logic               last_point;
   } req_type;

   typedef struct packed {
      logic [OID_W-1:0]   object_id;
      logic [1:0]         result_code;
      logic [COORD_W-1:0] box_left;
      logic [COORD_W-1:0] box_top;
      logic [SIZE_W-1:0]  box_width;
      logic [SIZE_W-1:0]  box_height;
   } rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0] min_x;
      logic [COORD_W-1:0] min_y;
      logic [COORD_W-1:0] max_x;
      logic [COORD_W-1:0] max_y;
   } box_type;

   typedef struct packed {
      logic            active;
      logic            matched;
      logic [ID_W-1:0] id;
   } tok_type;

   typedef struct packed {
      logic             new_wr;
      logic [CNT_W-1:0] count;
   } ctl_type;

   function automatic logic boxes_overlap(input box_type a, input box_type b);
      boxes_overlap = (a.min_x <= b.max_x) && (a.max_x >= b.min_x) &&
                      (a.min_y <= b.max_y) && (a.max_y >= b.min_y);
   endfunction

endpackage
`default_nettype wire

>>> src/box_overlap_id_tracker_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_overlap_id_tracker_unit: contour bounding box overlap tracker
// Builds a bounding box per contour and matches it against stored boxes.
// ----------------------------------------------------------------------------
// usage
//   req channel: one contour point per beat, last_point marks the end of a
//   contour. points that are not last are taken one per cycle.
//   rsp channel: one beat per contour with the id, result code and box.
//   walk: once the last point is accepted, req_stall stays high while the
//   match token walks the chain of MAX_OBJECTS table cells, one cell per
//   cycle, and on through the decide step until the result is loaded.
//   the result waits in an output register; while rsp_stall holds it, the
//   next contour's points are still accepted, and the following result
//   waits in the decide step until the register frees up.
//   csr port: index 0 y_start, 1 y_end, 2 edge_offset; write only while idle.
//   reset: entry count cleared, table contents unknown (never read before
//   written), y_start 0, y_end 4095, edge_offset 0, no beat pending.
// ----------------------------------------------------------------------------
module box_overlap_id_tracker_unit import bot_pkg::*; #(
   parameter int MAX_OBJECTS = 64
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output rsp_type            rsp_data,
   input  wire                csr_wr_en,
   input  wire  [1:0]         csr_index,
   input  wire  [COORD_W-1:0] csr_wdata
);

   localparam int COUNT_W = $clog2(MAX_OBJECTS + 1);

   typedef enum logic [2:0] {
      ST_COLLECT = 3'b001,
      ST_WALK    = 3'b010,
      ST_DECIDE  = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [COORD_W-1:0] y_start_ff, y_end_ff;
   logic [OFFS_W-1:0]  offset_ff;
   box_type            box_ff, box_in;
   logic               first_ff, first_in;
   logic               start_ff;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic               matched_ff, matched_in;
   logic [ID_W-1:0]    mid_ff, mid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               accept;
   logic               load;
   logic               new_wr;
   logic               in_band;
   logic               full;
   logic [SIZE_W-1:0]  bottom;
   logic [SIZE_W-1:0]  band_lo;
   logic signed [SIZE_W:0] band_hi;
   logic [COUNT_W+ID_W-1:0] cnt_ext;
   logic [ID_W-1:0]    res_id;
   code_type           res_code;
   ctl_type            ctl;
   tok_type            tok_w [0:MAX_OBJECTS];

   assign req_stall = (state_ff != ST_COLLECT);
   assign accept    = req_valid && !req_stall;

   // running bounding box
   always_comb begin
      box_in   = box_ff;
      first_in = first_ff;
      if (accept) begin
         if (first_ff) begin
            box_in.min_x = req_data.point_x;
            box_in.max_x = req_data.point_x;
            box_in.min_y = req_data.point_y;
            box_in.max_y = req_data.point_y;
         end else begin
            if (req_data.point_x < box_ff.min_x) box_in.min_x = req_data.point_x;
            if (req_data.point_x > box_ff.max_x) box_in.max_x = req_data.point_x;
            if (req_data.point_y < box_ff.min_y) box_in.min_y = req_data.point_y;
            if (req_data.point_y > box_ff.max_y) box_in.max_y = req_data.point_y;
         end
         first_in = req_data.last_point;
      end
   end

   // chain of table cells
   assign tok_w[0] = '{active: start_ff, matched: 1'b0, id: '0};
   assign ctl.new_wr = new_wr;
   assign ctl.count  = CNT_W'(cnt_ff);

   genvar gi;
   generate
      for (gi = 0; gi < MAX_OBJECTS; gi++) begin : g_cell
         bot_cell #(
            .INDEX (gi)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .box     (box_ff),
            .ctl     (ctl),
            .tok_in  (tok_w[gi]),
            .tok_out (tok_w[gi+1])
         );
      end
   endgenerate

   // new entry decision
   assign bottom  = {1'b0, box_ff.max_y} + SIZE_W'(1);
   assign band_lo = {1'b0, y_start_ff} + SIZE_W'(offset_ff);
   assign band_hi = $signed({2'b00, y_end_ff}) - $signed((SIZE_W+1)'(offset_ff));
   assign in_band = (bottom > band_lo) && ($signed({1'b0, bottom}) < band_hi);
   assign full    = (cnt_ff == COUNT_W'(MAX_OBJECTS));
   assign load    = (state_ff == ST_DECIDE) && (!rsp_valid_ff || !rsp_stall);
   assign new_wr  = load && !matched_ff && in_band && !full;
   assign cnt_ext = (COUNT_W+ID_W)'(cnt_ff);

   always_comb begin
      res_id   = '0;
      res_code = CODE_NONE;
      if (matched_ff) begin
         res_id   = mid_ff;
         res_code = CODE_MATCH;
      end else if (in_band && !full) begin
         res_id   = cnt_ext[ID_W-1:0];
         res_code = CODE_NEW;
      end else if (in_band) begin
         res_code = CODE_FULL;
      end
   end

   always_comb begin
      rsp_in.object_id   = res_id[OID_W-1:0];
      rsp_in.result_code = res_code;
      rsp_in.box_left    = box_ff.min_x;
      rsp_in.box_top     = box_ff.min_y;
      rsp_in.box_width   = {1'b0, box_ff.max_x} - {1'b0, box_ff.min_x} + SIZE_W'(1);
      rsp_in.box_height  = {1'b0, box_ff.max_y} - {1'b0, box_ff.min_y} + SIZE_W'(1);
   end

   // control
   always_comb begin
      state_in     = state_ff;
      matched_in   = matched_ff;
      mid_in       = mid_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_COLLECT: begin
            if (accept && req_data.last_point) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (tok_w[MAX_OBJECTS].active) begin
               matched_in = tok_w[MAX_OBJECTS].matched;
               mid_in     = tok_w[MAX_OBJECTS].id;
               state_in   = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_COLLECT;
               if (new_wr) cnt_in = cnt_ff + COUNT_W'(1);
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         first_ff     <= 1'b1;
         start_ff     <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         matched_ff   <= 1'b0;
         box_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         start_ff     <= accept && req_data.last_point;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         matched_ff   <= matched_in;
         box_ff       <= box_in;
      end
   end

   always_ff @(posedge clock) begin
      mid_ff <= mid_in;
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         y_start_ff <= '0;
         y_end_ff   <= '1;
         offset_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_Y_START:     y_start_ff <= csr_wdata;
            CSR_Y_END:       y_end_ff   <= csr_wdata;
            CSR_EDGE_OFFSET: offset_ff  <= csr_wdata[OFFS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= COUNT_W'(MAX_OBJECTS))
      else $error("entry count above table depth");

   a_token_in_walk: assert property (@(posedge clock) disable iff (reset)
      tok_w[MAX_OBJECTS].active |-> (state_ff == ST_WALK))
      else $error("token left the chain outside the walk");

   a_new_entry_count: assert property (@(posedge clock) disable iff (reset)
      new_wr |=> (cnt_ff == $past(cnt_ff) + COUNT_W'(1)) && rsp_valid_ff
                 && (rsp_ff.result_code == CODE_NEW))
      else $error("new entry not reflected in count and result");
`endif

endmodule
`default_nettype wire

>>> src/bot_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bot_cell: one table entry of the tracker chain
// Holds one stored box, loaded as a new entry; compares it with the broadcast
// box when the token passes, overwrites it on overlap and hands the token on.
// ----------------------------------------------------------------------------
module bot_cell import bot_pkg::*; #(
   parameter int INDEX = 0
) (
   input  wire     clock,
   input  wire     reset,
   input  box_type box,
   input  ctl_type ctl,
   input  tok_type tok_in,
   output tok_type tok_out
);

   box_type entry_ff;
   tok_type tok_ff;
   tok_type tok_in_next;
   logic    in_range;
   logic    hit;
   logic    new_sel;

   assign in_range = CNT_W'(INDEX) < ctl.count;
   assign hit      = tok_in.active && in_range && boxes_overlap(box, entry_ff);
   assign new_sel  = ctl.new_wr && (ctl.count == CNT_W'(INDEX));

   always_comb begin
      tok_in_next.active  = tok_in.active;
      tok_in_next.matched = tok_in.matched | hit;
      tok_in_next.id      = hit ? ID_W'(INDEX) : tok_in.id;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (hit || new_sel) begin
         entry_ff <= box;
      end
   end

   assign tok_out = tok_ff;

endmodule
`default_nettype wire

>>> tb/box_overlap_id_tracker_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_overlap_id_tracker_unit_tb: self-checking bench for the overlap tracker
// Streams contour points through the request channel and keeps its own box
// table and band settings. For every accepted last point it works out the
// expected id, result code and bounding box. Each result beat is compared
// with the oldest expected one. The run covers hand-picked edge contours,
// several band settings and a grid that fills the table. It then goes on with
// random contours, both fresh and near earlier ones, under varying backpressure.
// ----------------------------------------------------------------------------
module box_overlap_id_tracker_unit_tb import bot_pkg::*;;

   localparam int TRACK_DEPTH   = 64;
   localparam int COORD_MAX     = 4095;
   localparam int ANCHOR_DEPTH  = 32;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 400000;
   localparam logic [1:0] CSR_SPARE = 2'd3;

   bit                 clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_type            req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_type            rsp_data;
   logic               csr_wr_en = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [COORD_W-1:0] csr_wdata = '0;

   req_type point_queue[$];
   rsp_type expected_results[$];
   logic    req_taken = 1'b0;
   int      req_idle_pct = 0;
   int      rsp_idle_pct = 0;
   bit      hold_go = 1'b0;
   int      hold_left = 0;
   int      cycle_count = 0;
   int      mismatch_count = 0;

   // tracker state mirror
   logic [COORD_W-1:0] band_top = '0;
   logic [COORD_W-1:0] band_bottom = 12'd4095;
   logic [OFFS_W-1:0]  band_margin = '0;
   box_type            stored_box[TRACK_DEPTH];
   int                 stored_count = 0;
   logic [COORD_W-1:0] run_min_x, run_max_x, run_min_y, run_max_y;
   bit                 contour_open = 1'b0;

   int anchor_x[ANCHOR_DEPTH];
   int anchor_y[ANCHOR_DEPTH];
   int anchor_total = 0;

   box_overlap_id_tracker_unit #(.MAX_OBJECTS(TRACK_DEPTH)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void track_point(input req_type pt);
      box_type    nb;
      rsp_type    want;
      code_type   code;
      logic [7:0] hit_id;
      bit         hit;
      int         bottom, lo, hi, i;
      if (!contour_open) begin
         run_min_x = pt.point_x;
         run_max_x = pt.point_x;
         run_min_y = pt.point_y;
         run_max_y = pt.point_y;
         contour_open = 1'b1;
      end else begin
         if (pt.point_x < run_min_x) run_min_x = pt.point_x;
         if (pt.point_x > run_max_x) run_max_x = pt.point_x;
         if (pt.point_y < run_min_y) run_min_y = pt.point_y;
         if (pt.point_y > run_max_y) run_max_y = pt.point_y;
      end
      if (!pt.last_point) return;
      contour_open = 1'b0;
      nb.min_x = run_min_x;
      nb.min_y = run_min_y;
      nb.max_x = run_max_x;
      nb.max_y = run_max_y;
      hit = 1'b0;
      hit_id = '0;
      code = CODE_NONE;
      for (i = 0; i < stored_count; i++) begin
         if (nb.min_x <= stored_box[i].max_x && nb.max_x >= stored_box[i].min_x &&
             nb.min_y <= stored_box[i].max_y && nb.max_y >= stored_box[i].min_y) begin
            stored_box[i] = nb;
            hit_id = i[7:0];
            hit = 1'b1;
         end
      end
      if (hit) begin
         code = CODE_MATCH;
      end else begin
         bottom = int'(nb.max_y) + 1;
         lo = int'(band_top) + int'(band_margin);
         hi = int'(band_bottom) - int'(band_margin);
         if (bottom > lo && bottom < hi) begin
            if (stored_count < TRACK_DEPTH) begin
               hit_id = stored_count[7:0];
               stored_box[stored_count] = nb;
               stored_count++;
               code = CODE_NEW;
            end else begin
               code = CODE_FULL;
            end
         end
      end
      want.object_id   = hit_id[OID_W-1:0];
      want.result_code = code;
      want.box_left    = nb.min_x;
      want.box_top     = nb.min_y;
      want.box_width   = {1'b0, nb.max_x} - {1'b0, nb.min_x} + 13'd1;
      want.box_height  = {1'b0, nb.max_y} - {1'b0, nb.min_y} + 13'd1;
      expected_results.push_back(want);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("unexpected result beat, object_id", got.object_id, 0);
         return;
      end
      want = expected_results.pop_front();
      if (got.object_id !== want.object_id)
         report_mismatch("object_id", got.object_id, want.object_id);
      if (got.result_code !== want.result_code)
         report_mismatch("result_code", got.result_code, want.result_code);
      if (got.box_left !== want.box_left)
         report_mismatch("box_left", got.box_left, want.box_left);
      if (got.box_top !== want.box_top)
         report_mismatch("box_top", got.box_top, want.box_top);
      if (got.box_width !== want.box_width)
         report_mismatch("box_width", got.box_width, want.box_width);
      if (got.box_height !== want.box_height)
         report_mismatch("box_height", got.box_height, want.box_height);
   endtask

   // accept and check on the rising edge
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) track_point(req_data);
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
      end
   end

   // point driver
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (point_queue.size() != 0 && $urandom_range(0, 99) >= req_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= point_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result backpressure
   always @(negedge clock)
      rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < rsp_idle_pct);

   // long receiver hold-off
   always @(negedge clock) begin
      if (hold_go) begin
         hold_go = 1'b0;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic queue_point(input int x, input int y, input bit last);
      req_type pt;
      pt.point_x    = x[COORD_W-1:0];
      pt.point_y    = y[COORD_W-1:0];
      pt.last_point = last;
      point_queue.push_back(pt);
   endtask

   task automatic queue_random_points(input int target);
      int queued, n, span_x, span_y, ax, ay, k, i, px, py;
      queued = 0;
      while (queued < target) begin
         n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(8, 16)) :
                                            int'($urandom_range(1, 5));
         if ($urandom_range(0, 19) == 0) begin
            span_x = $urandom_range(0, COORD_MAX);
            span_y = $urandom_range(0, COORD_MAX);
         end else begin
            span_x = $urandom_range(0, 40);
            span_y = $urandom_range(0, 40);
         end
         if ($urandom_range(0, 1) == 1 && anchor_total != 0) begin
            k = $urandom_range(0, (anchor_total < ANCHOR_DEPTH ? anchor_total : ANCHOR_DEPTH) - 1);
            ax = anchor_x[k] + int'($urandom_range(0, 40)) - 20;
            ay = anchor_y[k] + int'($urandom_range(0, 40)) - 20;
         end else begin
            ax = $urandom_range(0, COORD_MAX);
            ay = $urandom_range(0, COORD_MAX);
         end
         anchor_x[anchor_total % ANCHOR_DEPTH] = ax;
         anchor_y[anchor_total % ANCHOR_DEPTH] = ay;
         anchor_total++;
         for (i = 0; i < n; i++) begin
            px = ax + int'($urandom_range(0, span_x));
            py = ay + int'($urandom_range(0, span_y));
            if (px > COORD_MAX) px = COORD_MAX;
            if (px < 0) px = 0;
            if (py > COORD_MAX) py = COORD_MAX;
            if (py < 0) py = 0;
            queue_point(px, py, i == n - 1);
         end
         queued += n;
      end
   endtask

   task automatic write_reg(input logic [1:0] idx, input int value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[COORD_W-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_Y_START:     band_top = value[COORD_W-1:0];
         CSR_Y_END:       band_bottom = value[COORD_W-1:0];
         CSR_EDGE_OFFSET: band_margin = value[OFFS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_band(input int top, input int bottom, input int margin);
      write_reg(CSR_Y_START, top);
      write_reg(CSR_Y_END, bottom);
      write_reg(CSR_EDGE_OFFSET, margin);
   endtask

   // drain everything in flight, then leave room for the match walk
   task automatic settle();
      while (point_queue.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (TRACK_DEPTH + 8) @(posedge clock);
   endtask

   initial begin
      int g;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      req_idle_pct = 33;
      rsp_idle_pct = 66;
      // whole frame with an empty table, then edge and overlap contours
      queue_point(4095, 4095, 1'b0);
      queue_point(0, 0, 1'b1);
      queue_point(10, 20, 1'b1);
      queue_point(4095, 0, 1'b1);
      queue_point(5, 15, 1'b0);
      queue_point(12, 25, 1'b0);
      queue_point(8, 18, 1'b1);
      queue_point(0, 4094, 1'b1);
      queue_point(0, 4093, 1'b1);
      queue_point(0, 0, 1'b1);
      queue_point(0, 0, 1'b0);
      queue_point(4095, 30, 1'b1);
      queue_point(100, 2000, 1'b0);
      queue_point(200, 2100, 1'b0);
      queue_point(150, 1990, 1'b1);
      settle();

      write_band(100, 3000, 50);
      queue_random_points(90);
      settle();

      write_band(0, 0, 0);
      write_reg(CSR_SPARE, $urandom_range(0, COORD_MAX));
      queue_random_points(80);
      settle();

      req_idle_pct = 66;
      rsp_idle_pct = 33;
      write_band(0, 4095, 0);
      // spread single-pixel contours so the table runs full
      for (g = 0; g < 84; g++)
         queue_point(40 + (g % 64) * 62, 3600 + (g % 5) * 40 + (g / 64) * 200, 1'b1);
      queue_random_points(20);
      settle();

      // bottom bound goes negative
      write_band(0, 300, 1023);
      queue_random_points(90);
      settle();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      write_band(4095, 4095, 1023);
      queue_random_points(90);
      @(posedge clock);
      hold_go = 1'b1;
      settle();

      write_band($urandom_range(0, 2000), $urandom_range(2000, COORD_MAX),
                 $urandom_range(0, 1023));
      queue_random_points(90);
      settle();

      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> files.f
src/bot_pkg.sv
src/bot_cell.sv
src/box_overlap_id_tracker_unit.sv
tb/box_overlap_id_tracker_unit_tb.sv
